>>> rtl/core/fcsg_pkg.sv
`timescale 1ns / 1ps
// package for the filled circle span generator
// holds field widths, setup constants and the span record type; no dependencies

package fcsg_pkg;

   localparam int COORD_W = 16;
   localparam int RAD_W = 4;
   localparam int LEN_W = 5;
   localparam int COLOR_W = 16;
   localparam int ROW_W = 4;
   localparam int SQ_W = 9;

   localparam int MAX_RADIUS_DEF = 15;

   // imax = r*707/1000 + 1, division by reciprocal multiply
   localparam int DIAG_NUM = 707;
   localparam int RECIP_1000 = 16778;
   localparam int RECIP_SHIFT = 24;

   localparam int MUL_A_W = 14;
   localparam int MUL_B_W = 15;
   localparam int PROD_W = 30;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [LEN_W-1:0]   len;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } span_type;

endpackage

>>> rtl/core/filled_circle_span_generator.sv
`timescale 1ns / 1ps
// filled circle span generator top level: circle in, horizontal fill spans out
// depends on fcsg_pkg
//
// usage:
//   req channel: one beat per circle (center, radius, color); accepted when
//   req_tvalid and req_tready are high. req_tready is high only while idle.
//   rsp channel: one beat per span, rsp_tlast marks the final span of a circle.
//   radius zero gives no beats; radius above MAX_RADIUS is clamped.
// timing:
//   one shared multiply-add unit does all multiplies under a sequencer.
//   setup runs r*707, the multiply by the reciprocal of 1000, r*r + r/2 and
//   the center row; then each row step i = 1..imax runs i*i, x*x + i*i, a
//   compare and the row's spans, and a flush state sends the last span.
//   the next circle is accepted once the sequencer is back in idle.
// reset: synchronous active-high reset empties the output and pending
//   registers and returns the sequencer to idle.
// stalls: spans pass through a pending register and an output register;
//   while rsp_tready is low with both full, the sequencer waits.

module filled_circle_span_generator #(
   parameter int MAX_RADIUS = fcsg_pkg::MAX_RADIUS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // center_x[15:0], center_y[31:16], radius[35:32], brush_color[51:36], zero pad
   input  logic [fcsg_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // span_x[15:0], span_y[31:16], span_len[36:32], span_color[52:37], zero pad
   output logic [fcsg_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL707 = 4'd1;
   localparam logic [3:0] ST_RECIP  = 4'd2;
   localparam logic [3:0] ST_SQ     = 4'd3;
   localparam logic [3:0] ST_CENTER = 4'd4;
   localparam logic [3:0] ST_ISQ    = 4'd5;
   localparam logic [3:0] ST_XSQ    = 4'd6;
   localparam logic [3:0] ST_CMP    = 4'd7;
   localparam logic [3:0] ST_OUT_P  = 4'd8;
   localparam logic [3:0] ST_OUT_M  = 4'd9;
   localparam logic [3:0] ST_IN_P   = 4'd10;
   localparam logic [3:0] ST_IN_M   = 4'd11;
   localparam logic [3:0] ST_FLUSH  = 4'd12;

   localparam int CW = fcsg_pkg::COORD_W;
   localparam int RW = fcsg_pkg::ROW_W;
   localparam int PW = fcsg_pkg::PROD_W;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [fcsg_pkg::COLOR_W-1:0] color_ff, color_in;
   logic [fcsg_pkg::RAD_W-1:0] r_ff, r_in;
   logic [RW-1:0] imax_ff, imax_in, i_ff, i_in, x_ff, x_in;
   logic [fcsg_pkg::SQ_W-1:0] sqmax_ff, sqmax_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic pend_v_ff, pend_v_in, out_v_ff, out_v_in, out_last_ff, out_last_in;
   fcsg_pkg::span_type pend_ff, pend_in, out_ff, out_in, cand;

   logic [fcsg_pkg::MUL_A_W-1:0] mul_a;
   logic [fcsg_pkg::MUL_B_W-1:0] mul_b;
   logic [fcsg_pkg::SQ_W-1:0] mul_c;
   logic [fcsg_pkg::RAD_W-1:0] r_clamp;
   logic emit, out_free, can_push, push, gt;

   // shared multiply-add unit
   always_comb begin
      prod_in = PW'(mul_a) * PW'(mul_b) + PW'(mul_c);
   end

   assign r_clamp = (32'(req_tdata[35:32]) > MAX_RADIUS) ?
                    fcsg_pkg::RAD_W'(MAX_RADIUS) : req_tdata[35:32];

   assign out_free = !out_v_ff || rsp_tready;
   assign can_push = !pend_v_ff || out_free;
   assign gt = prod_ff > PW'(sqmax_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_c = '0;
      cand = '0;
      emit = 1'b0;
      cand.color = color_ff;
      case (state_ff)
         ST_MUL707: begin
            mul_a = fcsg_pkg::MUL_A_W'(r_ff);
            mul_b = fcsg_pkg::MUL_B_W'(fcsg_pkg::DIAG_NUM);
         end
         ST_RECIP: begin
            mul_a = prod_ff[fcsg_pkg::MUL_A_W-1:0];
            mul_b = fcsg_pkg::MUL_B_W'(fcsg_pkg::RECIP_1000);
         end
         ST_SQ: begin
            mul_a = fcsg_pkg::MUL_A_W'(r_ff);
            mul_b = fcsg_pkg::MUL_B_W'(r_ff);
            mul_c = fcsg_pkg::SQ_W'(r_ff >> 1);
         end
         ST_CENTER: begin
            emit = 1'b1;
            cand.x = cx_ff - CW'(r_ff);
            cand.y = cy_ff;
            cand.len = {r_ff, 1'b0};
         end
         ST_ISQ: begin
            mul_a = fcsg_pkg::MUL_A_W'(i_ff);
            mul_b = fcsg_pkg::MUL_B_W'(i_ff);
         end
         ST_XSQ: begin
            mul_a = fcsg_pkg::MUL_A_W'(x_ff);
            mul_b = fcsg_pkg::MUL_B_W'(x_ff);
            mul_c = prod_ff[fcsg_pkg::SQ_W-1:0];
         end
         ST_OUT_P, ST_OUT_M: begin
            emit = 1'b1;
            cand.x = cx_ff - CW'(i_ff) + CW'(1);
            cand.y = (state_ff == ST_OUT_P) ? cy_ff + CW'(x_ff) : cy_ff - CW'(x_ff);
            cand.len = {i_ff - RW'(1), 1'b0};
         end
         ST_IN_P, ST_IN_M: begin
            emit = 1'b1;
            cand.x = cx_ff - CW'(x_ff);
            cand.y = (state_ff == ST_IN_P) ? cy_ff + CW'(i_ff) : cy_ff - CW'(i_ff);
            cand.len = {x_ff, 1'b0};
         end
         default: begin
         end
      endcase
   end

   // zero-length spans are skipped without touching the pending register
   assign push = emit && (cand.len != '0) && can_push;

   always_comb begin
      state_in = state_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      color_in = color_ff;
      r_in = r_ff;
      imax_in = imax_ff;
      sqmax_in = sqmax_ff;
      i_in = i_ff;
      x_in = x_ff;
      pend_v_in = pend_v_ff;
      pend_in = pend_ff;
      out_v_in = out_v_ff && !rsp_tready;
      out_in = out_ff;
      out_last_in = out_last_ff;

      if (push) begin
         if (pend_v_ff) begin
            out_v_in = 1'b1;
            out_in = pend_ff;
            out_last_in = 1'b0;
         end
         pend_v_in = 1'b1;
         pend_in = cand;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cx_in = req_tdata[15:0];
               cy_in = req_tdata[31:16];
               r_in = r_clamp;
               color_in = req_tdata[51:36];
               state_in = (r_clamp == '0) ? ST_FLUSH : ST_MUL707;
            end
         end
         ST_MUL707: state_in = ST_RECIP;
         ST_RECIP: state_in = ST_SQ;
         ST_SQ: begin
            imax_in = prod_ff[fcsg_pkg::RECIP_SHIFT +: RW] + RW'(1);
            state_in = ST_CENTER;
         end
         ST_CENTER: begin
            sqmax_in = prod_ff[fcsg_pkg::SQ_W-1:0];
            i_in = RW'(1);
            x_in = RW'(r_ff);
            if (can_push) begin
               state_in = ST_ISQ;
            end
         end
         ST_ISQ: state_in = ST_XSQ;
         ST_XSQ: state_in = ST_CMP;
         ST_CMP: begin
            if (gt && (x_ff > imax_ff)) begin
               state_in = ST_OUT_P;
            end else begin
               if (gt && (x_ff != '0)) begin
                  x_in = x_ff - RW'(1);
               end
               state_in = ST_IN_P;
            end
         end
         ST_OUT_P: begin
            if (can_push || cand.len == '0) begin
               state_in = ST_OUT_M;
            end
         end
         ST_OUT_M: begin
            if (can_push || cand.len == '0) begin
               x_in = x_ff - RW'(1);
               state_in = ST_IN_P;
            end
         end
         ST_IN_P: begin
            if (can_push || cand.len == '0) begin
               state_in = ST_IN_M;
            end
         end
         ST_IN_M: begin
            if (can_push || cand.len == '0) begin
               if (i_ff == imax_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  i_in = i_ff + RW'(1);
                  state_in = ST_ISQ;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_v_in = 1'b1;
               out_in = pend_ff;
               out_last_in = 1'b1;
               pend_v_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_v_ff <= pend_v_in;
         out_v_ff <= out_v_in;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      color_ff <= color_in;
      r_ff <= r_in;
      imax_ff <= imax_in;
      sqmax_ff <= sqmax_in;
      i_ff <= i_in;
      x_ff <= x_in;
      prod_ff <= prod_in;
      pend_ff <= pend_in;
      out_ff <= out_in;
      out_last_ff <= out_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast = out_last_ff;
   assign rsp_tdata = {3'b000, out_ff.color, out_ff.len, out_ff.y, out_ff.x};

endmodule
